@@ rtl/srfp_pkg.sv @@
// ----------------------------------------------------------------------------
// srfp_pkg
// Shared types and constants for the screen response frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package srfp_pkg;

  // Frame bytes
  localparam logic [7:0] HeaderByte       = 8'hAA;
  localparam logic [7:0] TypeTouchPress   = 8'h73;
  localparam logic [7:0] TypeTouchRelease = 8'h72;
  localparam logic [7:0] TypeCalibDone    = 8'hE4;
  localparam logic [7:0] TypeHandshake    = 8'h00;
  localparam logic [7:0] TypeKeyPress     = 8'h79;
  localparam logic [7:0] TypeKeyRelease   = 8'h78;

  localparam logic [7:0] TrailerBytes [4] = '{8'hCC, 8'h33, 8'hC3, 8'h3C};

  // Dense event codes as reported on event_res
  localparam logic [2:0] EvTouchPress   = 3'd0;
  localparam logic [2:0] EvTouchRelease = 3'd1;
  localparam logic [2:0] EvHandshake    = 3'd2;
  localparam logic [2:0] EvCalibDone    = 3'd3;
  localparam logic [2:0] EvKeyPress     = 3'd4;
  localparam logic [2:0] EvKeyRelease   = 3'd5;

  // Result handed from the frame tracker to the output stage
  typedef struct packed {
    logic        valid;
    logic [2:0]  event_res;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/srfp_if.sv @@
// ----------------------------------------------------------------------------
// srfp_in_if / srfp_out_if
// Valid/ready channels carrying received bytes and decoded events.
// ----------------------------------------------------------------------------
`default_nettype none

interface srfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [15:0] first_word;
  logic [15:0] second_word;

  modport source (output valid, output event_res, output first_word,
                  output second_word, input ready);
  modport sink   (input valid, input event_res, input first_word,
                  input second_word, output ready);
endinterface

`default_nettype wire

@@ rtl/srfp_fsm.sv @@
// ----------------------------------------------------------------------------
// srfp_fsm
// Frame tracker: phase, pending event and latched data bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module srfp_fsm
  import srfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  output result_t         result_o
);

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhType   = 4'd1;
  localparam logic [3:0] PhData0  = 4'd2;
  localparam logic [3:0] PhData1  = 4'd3;
  localparam logic [3:0] PhData2  = 4'd4;
  localparam logic [3:0] PhData3  = 4'd5;
  localparam logic [3:0] PhTrail0 = 4'd6;
  localparam logic [3:0] PhTrail1 = 4'd7;
  localparam logic [3:0] PhTrail2 = 4'd8;
  localparam logic [3:0] PhTrail3 = 4'd9;

  logic [3:0] phase_q, phase_d;
  logic [2:0] pend_q, pend_d;
  logic [7:0] data_q [4];
  logic       data_we;
  logic [1:0] data_idx;
  logic [1:0] trail_idx;
  logic       emit;
  logic [2:0] emit_code;

  assign data_idx  = 2'(phase_q - PhData0);
  assign trail_idx = 2'(phase_q - PhTrail0);

  always_comb begin
    phase_d   = phase_q;
    pend_d    = pend_q;
    data_we   = 1'b0;
    emit      = 1'b0;
    emit_code = pend_q;
    unique case (phase_q)
      PhIdle: begin
        if (rx_byte_i == HeaderByte) phase_d = PhType;
      end
      PhType: begin
        phase_d = PhIdle;
        case (rx_byte_i)
          TypeTouchPress: begin
            pend_d  = EvTouchPress;
            phase_d = PhData0;
          end
          TypeTouchRelease: begin
            emit      = 1'b1;
            emit_code = EvTouchRelease;
          end
          TypeCalibDone: begin
            pend_d  = EvCalibDone;
            phase_d = PhData2;
          end
          TypeHandshake: begin
            emit      = 1'b1;
            emit_code = EvHandshake;
          end
          TypeKeyPress: begin
            pend_d  = EvKeyPress;
            phase_d = PhData2;
          end
          TypeKeyRelease: begin
            pend_d  = EvKeyRelease;
            phase_d = PhData2;
          end
          default: phase_d = PhIdle;
        endcase
      end
      PhData0, PhData1, PhData2, PhData3: begin
        data_we = 1'b1;
        phase_d = phase_q + 4'd1;
      end
      PhTrail0, PhTrail1, PhTrail2: begin
        phase_d = (rx_byte_i == TrailerBytes[trail_idx]) ? phase_q + 4'd1 : PhIdle;
      end
      PhTrail3: begin
        phase_d = PhIdle;
        emit    = (rx_byte_i == TrailerBytes[trail_idx]);
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pend_q  <= EvTouchPress;
      data_q  <= '{default: 8'h00};
    end else if (accept_i) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      if (data_we) data_q[data_idx] <= rx_byte_i;
    end
  end

  // Emitting phases never write data, so the current bytes are reported.
  assign result_o.valid       = accept_i & emit;
  assign result_o.event_res   = emit_code;
  assign result_o.first_word  = {data_q[0], data_q[1]};
  assign result_o.second_word = {data_q[2], data_q[3]};

endmodule

`default_nettype wire

@@ rtl/srfp_out_reg.sv @@
// ----------------------------------------------------------------------------
// srfp_out_reg
// Result register holding one event until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module srfp_out_reg
  import srfp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire result_t result_i,
  output logic        free_o,
  srfp_out_if.source  out_o
);

  logic        valid_q;
  logic [2:0]  event_q;
  logic [15:0] first_q;
  logic [15:0] second_q;

  // Register can take a new result when empty or being drained this cycle.
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= result_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && result_i.valid) begin
      event_q  <= result_i.event_res;
      first_q  <= result_i.first_word;
      second_q <= result_i.second_word;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.event_res   = event_q;
  assign out_o.first_word  = first_q;
  assign out_o.second_word = second_q;

endmodule

`default_nettype wire

@@ rtl/screen_response_frame_parser.sv @@
// ----------------------------------------------------------------------------
// screen_response_frame_parser
// Recognizes touch screen response frames in a received byte stream.
// ----------------------------------------------------------------------------
// One byte request is taken per clock cycle while input ready is high.
// Each byte steps the frame tracker: header 0xAA, a type byte, four data
// bytes for a touch press or two for calibration done / key press / key
// release, then the trailer CC 33 C3 3C. Touch release and handshake frames
// complete right after the type byte. A completed frame puts one event (code
// plus the two latched 16-bit data words) into the result register in the
// cycle after its last byte is taken; the result then waits there until the
// sink takes it. Data bytes are kept as they arrive even if the trailer later
// fails, and short frames only overwrite the second word. A wrong byte
// anywhere in the trailer, or an unknown type byte, drops back to hunting for
// a header with no event. Input ready is low only while a result sits unread
// and the sink is not taking it this cycle, so with a ready sink the block
// runs at one byte per cycle; the single result register sets that figure.
// ----------------------------------------------------------------------------
`default_nettype none

module screen_response_frame_parser
  import srfp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  srfp_in_if.sink    in_i,
  srfp_out_if.source out_o
);

  result_t result;
  logic    free;
  logic    accept;

  // A byte is only taken when any event it makes has a place to go.
  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  srfp_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (in_i.rx_byte),
    .result_o  (result)
  );

  srfp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .result_i (result),
    .free_o   (free),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

@@ rtl/srfp_checker.sv @@
// ----------------------------------------------------------------------------
// srfp_checker
// Port-level checks for the screen response frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

module srfp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] out_event_i
);

  // Only a stuck unread result may hold off the byte stream.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a pending result");

  // A new result needs a byte taken the cycle before.
  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result appeared without an accepted byte");

  // Event codes are dense, 0 to 5.
  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_event_i != 3'd6 && out_event_i != 3'd7))
    else $error("event code out of range");

  // A waiting result is held until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_event_i)))
    else $error("pending result dropped or changed");

endmodule

bind screen_response_frame_parser srfp_checker u_srfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_event_i (out_o.event_res)
);

`default_nettype wire
